FILE: hdl/ss_pkg.sv
package ss_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SEL_START,
        S_SEL_FIRST,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B,
        S_OUT_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } t_res;

endpackage

FILE: hdl/ss_cmp.sv
module ss_cmp (
    input  logic signed [ss_pkg::DATA_W-1:0] i_a,
    input  logic signed [ss_pkg::DATA_W-1:0] i_b,
    output logic                             o_lt
);

    // strict signed compare, ties keep the earlier candidate
    assign o_lt = (i_a < i_b);

endmodule

FILE: hdl/ss_ctrl.sv
module ss_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [ss_pkg::DATA_W-1:0] i_value,
    input  logic                             i_last,
    output ss_pkg::t_res                     o_res,
    output logic                             o_res_valid,
    input  logic                             i_res_ready
);

    ss_pkg::t_state r_state, n_state;

    logic [ss_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic                             r_drop, n_drop;
    logic [ss_pkg::IDX_W-1:0]         r_i, n_i;
    logic [ss_pkg::IDX_W-1:0]         r_j, n_j;
    logic [ss_pkg::IDX_W-1:0]         r_k, n_k;
    logic [ss_pkg::IDX_W-1:0]         r_best_idx, n_best_idx;
    logic signed [ss_pkg::DATA_W-1:0] r_best_val, n_best_val;
    logic signed [ss_pkg::DATA_W-1:0] r_i_val, n_i_val;
    logic signed [ss_pkg::DATA_W-1:0] r_rd_data;

    logic signed [ss_pkg::DATA_W-1:0] r_mem [ss_pkg::MAX_ITEMS];

    logic [ss_pkg::IDX_W-1:0]         w_rd_addr;
    logic                             w_we;
    logic [ss_pkg::IDX_W-1:0]         w_wr_addr;
    logic signed [ss_pkg::DATA_W-1:0] w_wr_data;
    logic [ss_pkg::CNT_W-1:0]         w_cnt_m1;
    logic [ss_pkg::IDX_W-1:0]         w_last_idx;
    logic                             w_lt;

    assign w_cnt_m1   = r_cnt - ss_pkg::CNT_W'(1);
    assign w_last_idx = w_cnt_m1[ss_pkg::IDX_W-1:0];

    ss_cmp u_cmp (
        .i_a  (r_rd_data),
        .i_b  (r_best_val),
        .o_lt (w_lt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ss_pkg::S_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_best_idx <= n_best_idx;
        r_best_val <= n_best_val;
        r_i_val    <= n_i_val;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_drop      = r_drop;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_best_idx  = r_best_idx;
        n_best_val  = r_best_val;
        n_i_val     = r_i_val;
        w_rd_addr   = r_k;
        w_we        = 1'b0;
        w_wr_addr   = r_i;
        w_wr_data   = r_best_val;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ss_pkg::S_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (r_cnt < ss_pkg::CNT_W'(ss_pkg::MAX_ITEMS)) begin
                        w_we      = 1'b1;
                        w_wr_addr = r_cnt[ss_pkg::IDX_W-1:0];
                        w_wr_data = i_value;
                        n_cnt     = r_cnt + ss_pkg::CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last) begin
                        n_i = '0;
                        n_k = '0;
                        // a single stored value needs no sorting
                        if (n_cnt == ss_pkg::CNT_W'(1)) begin
                            n_state = ss_pkg::S_OUT_RD;
                        end else begin
                            n_state = ss_pkg::S_SEL_START;
                        end
                    end
                end
            end
            ss_pkg::S_SEL_START: begin
                w_rd_addr = r_i;
                n_state   = ss_pkg::S_SEL_FIRST;
            end
            ss_pkg::S_SEL_FIRST: begin
                n_best_val = r_rd_data;
                n_i_val    = r_rd_data;
                n_best_idx = r_i;
                n_j        = r_i + ss_pkg::IDX_W'(1);
                w_rd_addr  = r_i + ss_pkg::IDX_W'(1);
                n_state    = ss_pkg::S_SCAN;
            end
            ss_pkg::S_SCAN: begin
                // r_rd_data holds entry r_j, next entry is fetched meanwhile
                if (w_lt) begin
                    n_best_val = r_rd_data;
                    n_best_idx = r_j;
                end
                if (r_j == w_last_idx) begin
                    n_state = ss_pkg::S_SWAP_A;
                end else begin
                    n_j       = r_j + ss_pkg::IDX_W'(1);
                    w_rd_addr = r_j + ss_pkg::IDX_W'(1);
                end
            end
            ss_pkg::S_SWAP_A: begin
                w_we      = 1'b1;
                w_wr_addr = r_i;
                w_wr_data = r_best_val;
                n_state   = ss_pkg::S_SWAP_B;
            end
            ss_pkg::S_SWAP_B: begin
                w_we      = 1'b1;
                w_wr_addr = r_best_idx;
                w_wr_data = r_i_val;
                if (r_i == w_last_idx - ss_pkg::IDX_W'(1)) begin
                    n_k     = '0;
                    n_state = ss_pkg::S_OUT_RD;
                end else begin
                    n_i     = r_i + ss_pkg::IDX_W'(1);
                    n_state = ss_pkg::S_SEL_START;
                end
            end
            ss_pkg::S_OUT_RD: begin
                w_rd_addr = r_k;
                n_state   = ss_pkg::S_OUT;
            end
            ss_pkg::S_OUT: begin
                w_rd_addr   = r_k;
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    if (r_k == w_last_idx) begin
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_state = ss_pkg::S_LOAD;
                    end else begin
                        n_k     = r_k + ss_pkg::IDX_W'(1);
                        n_state = ss_pkg::S_OUT_RD;
                    end
                end
            end
        endcase
    end

    assign o_res.value = r_rd_data;
    assign o_res.last  = (r_k == w_last_idx);
    assign o_res.ovf   = r_drop;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ss_pkg::CNT_W'(ss_pkg::MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ss_pkg::S_SCAN) |-> (r_j > r_i) && (r_best_idx >= r_i)
                                        && (r_best_idx <= r_j))
        else $error("scan indexes out of order");

    a_sort_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ss_pkg::S_SEL_START) |-> (r_cnt >= ss_pkg::CNT_W'(2)))
        else $error("selection pass started on fewer than two values");

    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_cnt != '0) && (r_k <= w_last_idx))
        else $error("result issued past the stored run");

    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_res.last) |=>
            (r_state == ss_pkg::S_LOAD) && (r_cnt == '0) && !r_drop)
        else $error("run state not cleared after final result");

endmodule

FILE: hdl/selection_sorter.sv
// selection_sorter collects a run of signed 32-bit values, one per input
// transaction, until a transaction with i_last set. The run is then sorted
// in place in a 16-entry single-write-port store by one shared comparator:
// for each position the store is read and its first candidate latched, each
// remaining entry is compared in turn, and two swap writes follow.
// Each sorted value is then read from the store and handed off to the output
// register, with o_last_out on the final one. The input side is not ready
// from the last transaction of a run until the final result of that run has
// been handed off. Values beyond 16 are dropped and the whole run's results
// carry o_overflow.
module selection_sorter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [ss_pkg::DATA_W-1:0] i_value,
    input  logic                             i_last,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [ss_pkg::DATA_W-1:0] o_sorted_value,
    output logic                             o_last_out,
    output logic                             o_overflow
);

    ss_pkg::t_res w_res;
    logic         w_res_valid;
    logic         w_res_ready;

    logic                             r_valid;
    logic signed [ss_pkg::DATA_W-1:0] r_value;
    logic                             r_last;
    logic                             r_ovf;

    ss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready)
    );

    assign w_res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_value <= w_res.value;
            r_last  <= w_res.last;
            r_ovf   <= w_res.ovf;
        end
    end

    assign o_valid        = r_valid;
    assign o_sorted_value = r_value;
    assign o_last_out     = r_last;
    assign o_overflow     = r_ovf;

endmodule

FILE: bench/selection_sorter_checker.sv
`timescale 1ns / 1ps

module selection_sorter_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic signed [ss_pkg::DATA_W-1:0] i_value,
    input  logic                             i_last,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [ss_pkg::DATA_W-1:0] i_sorted_value,
    input  logic                             i_last_out,
    input  logic                             i_overflow,
    output int                               o_pending,
    output int                               o_fail_count,
    output int                               o_result_count
);

    // predicted copy of the block's run store
    logic signed [ss_pkg::DATA_W-1:0] run_store [ss_pkg::MAX_ITEMS];
    int                               run_fill    = 0;
    bit                               run_dropped = 1'b0;
    ss_pkg::t_res                     sorted_q [$];
    int                               fails       = 0;
    int                               results     = 0;

    always @(posedge i_clk) begin : predict_and_check
        ss_pkg::t_res                     want;
        logic signed [ss_pkg::DATA_W-1:0] swap;
        int                               best;
        if (!i_rst_n) begin
            sorted_q.delete();
            run_fill    = 0;
            run_dropped = 1'b0;
        end else begin
            // result transaction: compare against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                results++;
                if (sorted_q.size() == 0) begin
                    $error("unexpected result: sorted_value %0d, last_out %0b, overflow %0b",
                           i_sorted_value, i_last_out, i_overflow);
                    fails++;
                end else begin
                    want = sorted_q.pop_front();
                    if (i_sorted_value !== want.value) begin
                        $error("sorted_value mismatch: expected %0d, actual %0d",
                               want.value, i_sorted_value);
                        fails++;
                    end
                    if (i_last_out !== want.last) begin
                        $error("last_out mismatch: expected %0b, actual %0b",
                               want.last, i_last_out);
                        fails++;
                    end
                    if (i_overflow !== want.ovf) begin
                        $error("overflow mismatch: expected %0b, actual %0b",
                               want.ovf, i_overflow);
                        fails++;
                    end
                end
            end

            // input transaction: store or drop, sort when the run closes
            if (i_in_valid && i_in_ready) begin
                if (run_fill < ss_pkg::MAX_ITEMS) begin
                    run_store[run_fill] = i_value;
                    run_fill++;
                end else begin
                    run_dropped = 1'b1;
                end
                if (i_last) begin
                    for (int i = 0; i < run_fill; i++) begin
                        best = i;
                        // strict compare keeps the earlier entry on ties
                        for (int j = i + 1; j < run_fill; j++) begin
                            if (run_store[j] < run_store[best])
                                best = j;
                        end
                        swap            = run_store[i];
                        run_store[i]    = run_store[best];
                        run_store[best] = swap;
                    end
                    for (int i = 0; i < run_fill; i++) begin
                        want.value = run_store[i];
                        want.last  = (i == run_fill - 1);
                        want.ovf   = run_dropped;
                        sorted_q.push_back(want);
                    end
                    run_fill    = 0;
                    run_dropped = 1'b0;
                end
            end
        end
        o_pending      <= sorted_q.size();
        o_fail_count   <= fails;
        o_result_count <= results;
    end

endmodule

FILE: bench/selection_sorter_tb.sv
`timescale 1ns / 1ps

module selection_sorter_tb;

    localparam int ITEM_TARGET    = 320;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 250;
    localparam int TIMEOUT_CYCLES = 200_000;

    localparam logic signed [ss_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(ss_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [ss_pkg::DATA_W-1:0] VAL_MAX =
        {1'b0, {(ss_pkg::DATA_W-1){1'b1}}};

    logic                             i_clk;
    logic                             i_rst_n  = 1'b0;
    logic                             i_valid  = 1'b0;
    logic signed [ss_pkg::DATA_W-1:0] i_value  = '0;
    logic                             i_last   = 1'b0;
    logic                             i_ready  = 1'b0;
    logic                             hold_req = 1'b0;
    logic                             o_ready;
    logic                             o_valid;
    logic signed [ss_pkg::DATA_W-1:0] o_sorted_value;
    logic                             o_last_out;
    logic                             o_overflow;

    int pending_results;
    int fail_count;
    int result_count;

    int items_sent  = 0;
    int burst_left  = 0;
    int runs        = 0;
    int ovf_runs    = 0;
    bit offering    = 1'b0;
    int cycle_count = 0;

    selection_sorter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    selection_sorter_checker sort_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_value        (i_value),
        .i_last         (i_last),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_sorted_value (o_sorted_value),
        .i_last_out     (o_last_out),
        .i_overflow     (o_overflow),
        .o_pending      (pending_results),
        .o_fail_count   (fail_count),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // mix of wide random, clustered (ties) and boundary values
    function automatic logic signed [ss_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return $urandom;
        if (sel < 70)
            return int'($urandom_range(0, 8)) - 4;
        if (sel < 85)
            return int'($urandom_range(0, 131070)) - 65535;
        case ($urandom_range(0, 6))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_MIN + 1;
            3: return VAL_MAX - 1;
            4: return -1;
            5: return 1;
            default: return 0;
        endcase
    endfunction

    task automatic send_value(input logic signed [ss_pkg::DATA_W-1:0] v, input logic lst);
        int gap;
        i_valid  <= 1'b1;
        i_value  <= v;
        i_last   <= lst;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid  <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        if (offering) begin
            i_valid  <= 1'b0;
            offering = 1'b0;
        end
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    // result side: stall patterns, plus one long hold-off on request
    initial begin : receiver
        int  mode;
        int  span;
        int  held;
        bit  hold_done;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(10, 80);
            for (int k = 0; k < span; k++) begin
                @(posedge i_clk);
                if (hold_req && !hold_done) begin
                    i_ready <= 1'b0;
                    for (held = 1; held < LONG_HOLD; held++) @(posedge i_clk);
                    hold_done = 1'b1;
                end else begin
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= 1'($urandom_range(0, 1));
                        2: i_ready <= (k % 4 == 0);
                        3: i_ready <= ($urandom_range(0, 9) != 0);
                        default: i_ready <= (k % 8 >= 5);
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        int sel;
        int len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-value run at the top of the range
        send_value(VAL_MAX, 1'b1);
        // both extremes, zero and minus one in one run
        send_value(VAL_MIN, 1'b0);
        send_value(VAL_MAX, 1'b0);
        send_value(0, 1'b0);
        send_value(-1, 1'b1);
        // equal values land side by side
        send_value(5, 1'b0);
        send_value(-5, 1'b0);
        send_value(5, 1'b1);
        // overfull run: the seventeenth value, the last one, is dropped
        for (int k = 0; k < ss_pkg::MAX_ITEMS + 1; k++)
            send_value((k % 2) ? -k * 1000 : k * 1000003, k == ss_pkg::MAX_ITEMS);
        runs     = 4;
        ovf_runs = 1;
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                len = $urandom_range(1, 6);
            else if (sel < 92)
                len = $urandom_range(7, ss_pkg::MAX_ITEMS);
            else
                len = $urandom_range(ss_pkg::MAX_ITEMS + 1, ss_pkg::MAX_ITEMS + 4);
            for (int k = 0; k < len; k++)
                send_value(pick_value(), k == len - 1);
            runs++;
            if (len > ss_pkg::MAX_ITEMS)
                ovf_runs++;
            if (runs == 8)
                hold_req <= 1'b1;
            if (runs % 15 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sorted %0d runs from %0d input transactions, %0d runs overfull",
                 runs, items_sent, ovf_runs);
        $display("%0d results compared, %0d mismatches", result_count, fail_count);
        if (fail_count == 0 && pending_results == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
